// File: rtl/nbl_pkg.sv
package nbl_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int COORD_BITS  = 24;

	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int SPAN_W = 26;
	localparam int DIST_W = 27;
	localparam int SUM_W  = COORD_BITS + 3;
	localparam int LIM_W  = 28;
	localparam int OUT_IDX_W = 6;
	localparam int OUT_CNT_W = 7;

	localparam logic [LIM_W-1:0]  BEST_LIMIT = LIM_W'(999999 * 256);
	localparam logic [SPAN_W-1:0] SPAN_MAX   = '1;
	localparam logic [DIST_W-1:0] DIST_MAX   = '1;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_SPARE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ADDED      = 3'd0,
		ST_FULL       = 3'd1,
		ST_NOT_LOADED = 3'd2,
		ST_INSIDE     = 3'd3,
		ST_NEAREST    = 3'd4,
		ST_NONE       = 3'd5,
		ST_CLEARED    = 3'd6
	} status_t;

	typedef enum logic {
		REG_Z_MARGIN  = 1'b0,
		REG_TOLERANCE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] min_x;
		logic signed [COORD_BITS-1:0] min_y;
		logic signed [COORD_BITS-1:0] min_z;
		logic signed [COORD_BITS-1:0] max_x;
		logic signed [COORD_BITS-1:0] max_y;
		logic signed [COORD_BITS-1:0] max_z;
		logic [SPAN_W-1:0]            span;
	} box_t;

	// query token walking down the row of cells
	typedef struct packed {
		logic                         valid;
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
		logic signed [COORD_BITS-1:0] pz;
		logic                         hit;
		logic                         found;
		logic [DIST_W-1:0]            best_d;
		logic [IDX_W-1:0]             best_idx;
	} token_t;

	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] d;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		return d[COORD_BITS] ? COORD_BITS'(-d) : d[COORD_BITS-1:0];
	endfunction

endpackage

// File: rtl/nbl_cell.sv
module nbl_cell
	import nbl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] cell_idx,
	input  logic [CNT_W-1:0] count,
	input  logic [7:0]       tol,
	input  logic             wr_en,
	input  box_t             wr_box,
	input  token_t           tok_in,
	output token_t           tok_out
);

	box_t   box_q;
	token_t tok_q;
	token_t tok_d;

	logic              active;
	logic [SUM_W-1:0]  s;
	logic [DIST_W-1:0] d;
	logic [LIM_W-1:0]  bound;

	always_comb begin
		active = {1'b0, cell_idx} < count;
		s = SUM_W'(abs_diff(box_q.min_x, tok_in.px)) + SUM_W'(abs_diff(box_q.max_x, tok_in.px))
		  + SUM_W'(abs_diff(box_q.min_y, tok_in.py)) + SUM_W'(abs_diff(box_q.max_y, tok_in.py))
		  + SUM_W'(abs_diff(box_q.min_z, tok_in.pz)) + SUM_W'(abs_diff(box_q.max_z, tok_in.pz));
		if (s < SUM_W'(box_q.span))
			d = '0;
		else if ((s - SUM_W'(box_q.span)) > SUM_W'(DIST_MAX))
			d = DIST_MAX;
		else
			d = DIST_W'(s - SUM_W'(box_q.span));
		bound = tok_in.found ? LIM_W'(tok_in.best_d) : BEST_LIMIT;
		tok_d = tok_in;
		if (tok_in.valid && active && !tok_in.hit) begin
			if (d < DIST_W'(tol)) begin
				tok_d.hit      = 1'b1;
				tok_d.best_d   = d;
				tok_d.best_idx = cell_idx;
			end else if (LIM_W'(d) < bound) begin
				tok_d.found    = 1'b1;
				tok_d.best_d   = d;
				tok_d.best_idx = cell_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			box_q <= wr_box;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

// File: rtl/nearest_box_lookup_top.sv
// channel   | direction | signals                                      | handshake
// command   | in        | cmd, a_x, a_y, a_z, b_x, b_y, b_z             | start && !busy
// result    | out       | status, entry_index, distance, entry_count   | done, one cycle
// config    | in        | cfg_index, cfg_data                          | cfg_valid && cfg_ready
//
// clear and add give their result in the cycle after the start transaction
// a query walks the row of box cells, one cell per cycle, with busy high until it leaves the last cell,
// and the result is then registered; an empty table answers in the cycle after the start transaction
// reset empties the table and loads the register defaults; cell contents are not cleared
// the result cannot be stalled; config is always ready
module nearest_box_lookup_top
	import nbl_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   cmd,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] a_z,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic signed [COORD_BITS-1:0] b_z,
	output logic                         done,
	output logic [2:0]                   status,
	output logic [OUT_IDX_W-1:0]         entry_index,
	output logic [DIST_W-1:0]            distance,
	output logic [OUT_CNT_W-1:0]         entry_count,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [15:0]                  cfg_data
);

	localparam logic signed [COORD_BITS+1:0] C_HI = (COORD_BITS+2)'((1 << (COORD_BITS-1)) - 1);
	localparam logic signed [COORD_BITS+1:0] C_LO = -C_HI - (COORD_BITS+2)'(1);

	logic [15:0]      z_margin_q;
	logic [7:0]       tol_q;
	logic [CNT_W-1:0] held_q;
	logic             query_q;

	logic             done_q;
	status_t          status_q;
	logic [IDX_W-1:0] idx_q;
	logic [DIST_W-1:0] dist_q;

	logic    accept;
	cmd_t    c;
	logic    full;
	box_t    nbox;
	token_t  tok [MAX_ENTRIES+1];

	logic signed [COORD_BITS-1:0] lo_z, hi_z;
	logic signed [COORD_BITS+1:0] zl, zh;
	logic [SPAN_W-1:0]            sp;

	always_comb begin
		accept = start && !busy;
		c      = cmd_t'(cmd);
		full   = held_q >= CNT_W'(MAX_ENTRIES);
		nbox.min_x = (a_x > b_x) ? b_x : a_x;
		nbox.max_x = (a_x > b_x) ? a_x : b_x;
		nbox.min_y = (a_y > b_y) ? b_y : a_y;
		nbox.max_y = (a_y > b_y) ? a_y : b_y;
		lo_z = (a_z > b_z) ? b_z : a_z;
		hi_z = (a_z > b_z) ? a_z : b_z;
		// spans are unsigned and may use the top bit
		sp = SPAN_W'($unsigned(COORD_BITS'(nbox.max_x - nbox.min_x)))
		   + SPAN_W'($unsigned(COORD_BITS'(nbox.max_y - nbox.min_y)))
		   + SPAN_W'($unsigned(COORD_BITS'(hi_z - lo_z)));
		nbox.span = sp;
		zl = (COORD_BITS+2)'(lo_z) - (COORD_BITS+2)'({1'b0, z_margin_q});
		zh = (COORD_BITS+2)'(hi_z) + (COORD_BITS+2)'({1'b0, z_margin_q});
		nbox.min_z = (zl < C_LO) ? COORD_BITS'(C_LO) : COORD_BITS'(zl);
		nbox.max_z = (zh > C_HI) ? COORD_BITS'(C_HI) : COORD_BITS'(zh);
		tok[0].valid    = accept && (c == CMD_QUERY || c == CMD_SPARE) && (held_q != '0);
		tok[0].px       = a_x;
		tok[0].py       = a_y;
		tok[0].pz       = a_z;
		tok[0].hit      = 1'b0;
		tok[0].found    = 1'b0;
		tok[0].best_d   = '0;
		tok[0].best_idx = '0;
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		nbl_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_idx(IDX_W'(i)),
			.count   (held_q),
			.tol     (tol_q),
			.wr_en   (accept && c == CMD_ADD && !full && held_q == CNT_W'(i)),
			.wr_box  (nbox),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_margin_q <= 16'd8192;
			tol_q      <= 8'd3;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_Z_MARGIN:  z_margin_q <= cfg_data;
				REG_TOLERANCE: tol_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			query_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (tok[0].valid) begin
				query_q <= 1'b1;
			end else if (tok[MAX_ENTRIES].valid) begin
				query_q <= 1'b0;
				done_q  <= 1'b1;
			end else if (accept) begin
				done_q <= 1'b1;
				if (c == CMD_CLEAR) begin
					held_q <= '0;
				end else if (c == CMD_ADD && !full) begin
					held_q <= held_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok[MAX_ENTRIES].valid) begin
			if (tok[MAX_ENTRIES].hit) begin
				status_q <= ST_INSIDE;
				idx_q    <= tok[MAX_ENTRIES].best_idx;
				dist_q   <= tok[MAX_ENTRIES].best_d;
			end else if (tok[MAX_ENTRIES].found) begin
				status_q <= ST_NEAREST;
				idx_q    <= tok[MAX_ENTRIES].best_idx;
				dist_q   <= tok[MAX_ENTRIES].best_d;
			end else begin
				status_q <= ST_NONE;
				idx_q    <= '0;
				dist_q   <= '0;
			end
		end else if (accept) begin
			dist_q <= '0;
			unique case (c)
				CMD_CLEAR: begin
					status_q <= ST_CLEARED;
					idx_q    <= '0;
				end
				CMD_ADD: begin
					status_q <= full ? ST_FULL : ST_ADDED;
					idx_q    <= full ? '0 : IDX_W'(held_q);
				end
				default: begin
					status_q <= ST_NOT_LOADED;
					idx_q    <= '0;
				end
			endcase
		end
	end

	assign busy        = query_q;
	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign status      = status_q;
	assign entry_index = OUT_IDX_W'(idx_q);
	assign distance    = dist_q;
	assign entry_count = OUT_CNT_W'(held_q);

endmodule

// File: tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import nbl_pkg::*;

	typedef struct {
		logic [1:0] op;
		logic signed [COORD_BITS-1:0] ax, ay, az, bx, by, bz;
	} box_cmd_t;

	typedef struct {
		logic [2:0] st;
		logic [OUT_IDX_W-1:0] idx;
		logic [DIST_W-1:0] dval;
		logic [OUT_CNT_W-1:0] cnt;
	} lookup_res_t;

	logic clk = 0, arst_n = 0;
	logic start = 0, busy, done, cfg_valid = 0, cfg_ready, cfg_index = 0;
	logic [1:0] cmd = 0;
	logic signed [COORD_BITS-1:0] a_x = 0, a_y = 0, a_z = 0, b_x = 0, b_y = 0, b_z = 0;
	logic [2:0] status;
	logic [OUT_IDX_W-1:0] entry_index;
	logic [DIST_W-1:0] distance;
	logic [OUT_CNT_W-1:0] entry_count;
	logic [15:0] cfg_data = 0;

	nearest_box_lookup_top DUT (.*);

	always #5 clk = ~clk;

	// predictor state
	longint bmin_x[MAX_ENTRIES], bmin_y[MAX_ENTRIES], bmin_z[MAX_ENTRIES];
	longint bmax_x[MAX_ENTRIES], bmax_y[MAX_ENTRIES], bmax_z[MAX_ENTRIES];
	longint bspan[MAX_ENTRIES];
	int held = 0;
	longint zmargin = 8192, tol = 3;

	box_cmd_t pending[$];
	lookup_res_t awaited[$];
	int errors = 0, idle_pct = 0, loaded = 0;
	bit stim_done = 0;

	function automatic longint csat(longint v);
		longint hi = (64'sd1 <<< (COORD_BITS-1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic longint adiff(longint a, longint b);
		return a >= b ? a - b : b - a;
	endfunction

	function automatic lookup_res_t predict_lookup(box_cmd_t c);
		lookup_res_t r;
		longint lo, hi, span, s, d, best;
		int bi;
		bit found;
		r.idx = 0; r.dval = 0;
		if (c.op == CMD_CLEAR) begin
			held = 0;
			r.st = ST_CLEARED;
		end else if (c.op == CMD_ADD) begin
			if (held >= MAX_ENTRIES) begin
				r.st = ST_FULL;
			end else begin
				bmin_x[held] = c.ax < c.bx ? c.ax : c.bx;
				bmax_x[held] = c.ax < c.bx ? c.bx : c.ax;
				bmin_y[held] = c.ay < c.by ? c.ay : c.by;
				bmax_y[held] = c.ay < c.by ? c.by : c.ay;
				lo = c.az < c.bz ? c.az : c.bz;
				hi = c.az < c.bz ? c.bz : c.az;
				span = bmax_x[held] - bmin_x[held] + bmax_y[held] - bmin_y[held] + hi - lo;
				bspan[held] = span > 64'h3FFFFFF ? 64'h3FFFFFF : span;
				bmin_z[held] = csat(lo - zmargin);
				bmax_z[held] = csat(hi + zmargin);
				r.st = ST_ADDED;
				r.idx = OUT_IDX_W'(held);
				held++;
			end
		end else if (held == 0) begin
			r.st = ST_NOT_LOADED;
		end else begin
			best = 64'd999999 * 256;
			bi = 0; found = 0;
			r.st = ST_NONE;
			for (int k = 0; k < held; k++) begin
				s = adiff(bmin_x[k], c.ax) + adiff(bmax_x[k], c.ax) + adiff(bmin_y[k], c.ay)
					+ adiff(bmax_y[k], c.ay) + adiff(bmin_z[k], c.az) + adiff(bmax_z[k], c.az);
				d = s >= bspan[k] ? s - bspan[k] : 0;
				if (d > 64'h7FFFFFF) d = 64'h7FFFFFF;
				if (d < tol) begin
					r.st = ST_INSIDE; r.idx = OUT_IDX_W'(k); r.dval = DIST_W'(d);
					r.cnt = OUT_CNT_W'(held);
					return r;
				end
				if (d < best) begin
					best = d; bi = k; found = 1;
				end
			end
			if (found) begin
				r.st = ST_NEAREST; r.idx = OUT_IDX_W'(bi); r.dval = DIST_W'(best);
			end
		end
		r.cnt = OUT_CNT_W'(held);
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				awaited.push_back(predict_lookup(pending.pop_front()));
			end
			if ((!start || !busy) && pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
				box_cmd_t c;
				c = pending[0];
				start <= 1;
				cmd <= c.op; a_x <= c.ax; a_y <= c.ay; a_z <= c.az;
				b_x <= c.bx; b_y <= c.by; b_z <= c.bz;
			end else if (start && !busy) begin
				start <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			lookup_res_t e;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result status %0d", status);
			end else begin
				e = awaited.pop_front();
				if (status !== e.st || entry_index !== e.idx || distance !== e.dval
						|| entry_count !== e.cnt) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp st %0d idx %0d dist %0d cnt %0d, got %0d %0d %0d %0d",
							e.st, e.idx, e.dval, e.cnt, status, entry_index, distance, entry_count);
				end
			end
		end
	end

	function automatic logic signed [COORD_BITS-1:0] rnd_coord(int mode);
		case (mode)
			0: return COORD_BITS'($urandom);
			1: return COORD_BITS'($urandom_range(4000) - 2000);
			default: return $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
		endcase
	endfunction

	task automatic queue_cmd(logic [1:0] op, int mode);
		box_cmd_t c;
		c.op = op;
		c.ax = rnd_coord(mode); c.ay = rnd_coord(mode); c.az = rnd_coord(mode);
		c.bx = rnd_coord(mode); c.by = rnd_coord(mode); c.bz = rnd_coord(mode);
		pending.push_back(c);
	endtask

	task automatic queue_fixed(logic [1:0] op, longint x, longint y, longint z,
			longint u, longint v, longint w);
		box_cmd_t c;
		c.op = op;
		c.ax = COORD_BITS'(x); c.ay = COORD_BITS'(y); c.az = COORD_BITS'(z);
		c.bx = COORD_BITS'(u); c.by = COORD_BITS'(v); c.bz = COORD_BITS'(w);
		pending.push_back(c);
	endtask

	task automatic drain;
		while (pending.size() != 0 || awaited.size() != 0 || start) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == REG_Z_MARGIN) zmargin = val;
		else tol = val[7:0];
	endtask

	initial begin
		int n;
		int m;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		// directed: empty query, extremes, overflow, cmd 3, full table
		queue_fixed(CMD_QUERY, 0, 0, 0, 0, 0, 0);
		queue_fixed(CMD_ADD, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF,
			-24'sh800000, 24'sh7FFFFF, -24'sh800000);
		queue_fixed(CMD_ADD, 100, 100, 100, -100, -100, -100);
		queue_fixed(CMD_QUERY, 0, 0, 0, 5, 5, 5);
		queue_fixed(CMD_SPARE, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0);
		queue_fixed(CMD_QUERY, -24'sh800000, -24'sh800000, -24'sh800000, 0, 0, 0);
		queue_fixed(CMD_CLEAR, 1, 2, 3, 4, 5, 6);
		queue_fixed(CMD_ADD, 0, 0, 0, 0, 0, 0);
		queue_fixed(CMD_QUERY, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0);
		queue_fixed(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 66; i++) queue_cmd(CMD_ADD, 1);
		queue_fixed(CMD_QUERY, 0, 0, 0, 0, 0, 0);
		drain();
		write_reg(REG_Z_MARGIN, 16'hFFFF);
		write_reg(REG_TOLERANCE, 16'h00FF);
		queue_fixed(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		queue_fixed(CMD_ADD, 24'sh7FFFF0, 0, 24'sh7FFFF0, 24'sh7FFFF0, 0, -24'sh7FFFF0);
		queue_fixed(CMD_QUERY, 24'sh7FFFF0, 0, 0, 0, 0, 0);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			idle_pct = (ph % 3 == 1) ? 50 : (ph % 3 == 2) ? 10 : 0;
			case (ph)
				1: begin write_reg(REG_Z_MARGIN, 0); write_reg(REG_TOLERANCE, 0); end
				2: begin
					write_reg(REG_Z_MARGIN, 16'($urandom));
					write_reg(REG_TOLERANCE, 16'($urandom));
				end
				3: begin write_reg(REG_Z_MARGIN, 8192); write_reg(REG_TOLERANCE, 3); end
				4: write_reg(REG_TOLERANCE, 16'h00FF);
				default: ;
			endcase
			n = 0;
			while (n < 300) begin
				// mostly query around a few filled boxes, with some adds and rare clears
				m = $urandom_range(99);
				if (m < 3) queue_cmd(CMD_CLEAR, 1);
				else if (m < 40) queue_cmd(CMD_ADD, m < 8 ? 0 : (m < 10 ? 2 : 1));
				else queue_cmd(m < 45 ? CMD_SPARE : CMD_QUERY, m < 50 ? 0 : (m < 52 ? 2 : 1));
				n++;
			end
			drain();
		end
		stim_done = 1;
		if (errors == 0 && awaited.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end
endmodule
